>>> hdl/mpsm_pkg.sv
// shared constants for the multi-pattern string matcher
package mpsm_pkg;

  localparam int MAX_NODES_DEF   = 4096;
  localparam int ALPHABET_DEF    = 26;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int REQ_W    = 3;
  localparam int LETTER_W = 5;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 16;
  localparam int USED_W   = 13;

  localparam logic [REQ_W-1:0] REQ_PAT_LETTER = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PAT_END    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BUILD      = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TXT_LETTER = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TXT_END    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;

endpackage

>>> hdl/multi_pattern_string_matcher_top.sv
// aho-corasick matcher top level: request sequencer around the trie, node and queue rams
//
// Every request returns one result. A pattern letter that allocates a node zeroes the new
// node's child row one entry per cycle through the child ram write port. A text letter
// follows failure links, then walks the count chain until it reaches the root or a node
// already counted. The build walks every node's ALPHABET child slots and follows failure
// links for each child it finds. After reset and after a clear request the root row is
// zeroed, during which no request is taken. A finished result waits in an output register
// while the next request is accepted.
module multi_pattern_string_matcher_top #(
  parameter int MAX_NODES   = mpsm_pkg::MAX_NODES_DEF,
  parameter int ALPHABET    = mpsm_pkg::ALPHABET_DEF,
  parameter int COUNT_WIDTH = mpsm_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // req_type[2:0], letter[7:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // status[1:0], match_total[17:2], nodes_used[30:18], zero
);
  import mpsm_pkg::*;

  localparam int AW   = $clog2(MAX_NODES);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int CIW  = $clog2(ALPHABET + 1);
  localparam int CD   = MAX_NODES * ALPHABET;
  localparam int CAW  = $clog2(CD);
  localparam int NW   = AW + COUNT_WIDTH + 1;

  localparam logic [4:0] S_IDLE = 5'd0,  S_DONE = 5'd1,  S_INIT = 5'd2,  S_PL_RD = 5'd3,
                         S_PL_CHK = 5'd4, S_ALLOC = 5'd5, S_PE_RD = 5'd6, S_PE_WR = 5'd7,
                         S_B_INIT = 5'd8, S_B_POP = 5'd9, S_B_T = 5'd10, S_B_TF = 5'd11,
                         S_B_CRD = 5'd12, S_B_CCHK = 5'd13, S_B_PRD = 5'd14,
                         S_B_PCHK = 5'd15, S_B_PF = 5'd16, S_B_WR = 5'd17, S_B_WR2 = 5'd18,
                         S_T_RD = 5'd19, S_T_CHK = 5'd20, S_T_F = 5'd21, S_T_CNT = 5'd22,
                         S_T_CNT2 = 5'd23;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [CIW-1:0] C_LAST = CIW'(ALPHABET - 1);

  function automatic logic [CAW-1:0] caddr(input logic [AW-1:0] n, input logic [CIW-1:0] c);
    return CAW'(n) * CAW'(ALPHABET) + CAW'(c);
  endfunction

  logic [4:0]             state;
  logic [LETTER_W-1:0]    letter;
  logic [AW-1:0]          ins_cur, mat_cur, tnode, tfail, chn, pn, fval;
  logic [NCW-1:0]         node_count, head, tail;
  logic [COUNT_WIDTH-1:0] match_sum;
  logic                   built, lost, clr_pending;
  logic [STATUS_W-1:0]    st;
  logic [CIW-1:0]         cidx;
  logic [31:0]            out_data;
  logic                   out_valid;

  // ram ports
  logic [AW-1:0]  cr_node, cw_node;
  logic [CIW-1:0] cr_c, cw_c;
  logic           c_we;
  logic [AW-1:0]  c_wdata, c_rdata;
  logic           n_we;
  logic [AW-1:0]  n_waddr, n_raddr;
  logic [NW-1:0]  n_wdata, n_rdata;
  logic           q_we;
  logic [AW-1:0]  q_waddr, q_wdata, q_rdata;

  logic [AW-1:0]          nrd_fail;
  logic [COUNT_WIDTH-1:0] nrd_cnt;
  logic                   nrd_mark;
  logic [COUNT_WIDTH:0]   sum_wide;
  logic [LETTER_W-1:0]    in_letter;
  logic [REQ_W-1:0]       in_req;
  logic                   in_letter_ok;

  assign nrd_fail = n_rdata[AW-1:0];
  assign nrd_cnt  = n_rdata[AW+COUNT_WIDTH-1:AW];
  assign nrd_mark = n_rdata[NW-1];
  assign sum_wide = {1'b0, match_sum} + {1'b0, nrd_cnt};

  assign in_req       = s_tdata[REQ_W-1:0];
  assign in_letter    = s_tdata[REQ_W+LETTER_W-1:REQ_W];
  assign in_letter_ok = 32'(in_letter) < 32'(ALPHABET);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  mpsm_ram #(.WIDTH(AW), .DEPTH(CD)) u_child (
    .clk(clk), .we(c_we), .waddr(caddr(cw_node, cw_c)), .wdata(c_wdata),
    .raddr(caddr(cr_node, cr_c)), .rdata(c_rdata)
  );

  mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  mpsm_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head[AW-1:0]), .rdata(q_rdata)
  );

  always_comb begin
    cr_node = pn;
    cr_c    = CIW'(letter);
    cw_node = ins_cur;
    cw_c    = CIW'(letter);
    c_we    = 1'b0;
    c_wdata = '0;
    n_raddr = pn;
    n_we    = 1'b0;
    n_waddr = tnode;
    n_wdata = n_rdata;
    q_we    = 1'b0;
    q_waddr = tail[AW-1:0];
    q_wdata = chn;
    unique case (state)
      S_INIT: begin
        c_we    = 1'b1;
        cw_node = '0;
        cw_c    = cidx;
      end
      S_PL_RD: cr_node = ins_cur;
      S_PL_CHK: begin
        // link a fresh node into the slot and reset its node entry
        if (c_rdata == '0 && !(node_count >= NCW'(MAX_NODES))) begin
          c_we    = 1'b1;
          c_wdata = AW'(node_count);
          n_we    = 1'b1;
          n_waddr = AW'(node_count);
          n_wdata = '0;
        end
      end
      S_ALLOC: begin
        c_we    = 1'b1;
        cw_node = ins_cur;
        cw_c    = cidx;
      end
      S_PE_RD: n_raddr = ins_cur;
      S_PE_WR: begin
        n_we    = 1'b1;
        n_waddr = ins_cur;
        n_wdata = {nrd_mark, (nrd_cnt == CNT_MAX) ? nrd_cnt : nrd_cnt + 1'b1, nrd_fail};
      end
      S_B_INIT: begin
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = '0;
      end
      S_B_T: n_raddr = q_rdata;
      S_B_CRD: begin
        cr_node = tnode;
        cr_c    = cidx;
      end
      S_B_PRD: cr_c = cidx;
      S_B_PCHK: n_raddr = pn;
      S_B_WR: n_raddr = chn;
      S_B_WR2: begin
        n_we    = 1'b1;
        n_waddr = chn;
        n_wdata = {nrd_mark, nrd_cnt, fval};
        q_we    = 1'b1;
      end
      S_T_CHK: n_raddr = pn;
      S_T_CNT: n_raddr = tnode;
      S_T_CNT2: begin
        if (!nrd_mark) begin
          n_we    = 1'b1;
          n_waddr = tnode;
          n_wdata = {1'b1, nrd_cnt, nrd_fail};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      cidx        <= '0;
      ins_cur     <= '0;
      mat_cur     <= '0;
      node_count  <= NCW'(1);
      match_sum   <= '0;
      built       <= 1'b0;
      lost        <= 1'b0;
      clr_pending <= 1'b0;
      out_valid   <= 1'b0;
      head        <= '0;
      tail        <= '0;
    end else begin
      if (m_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            letter <= in_letter;
            st     <= ST_OK;
            state  <= S_DONE;
            priority case (in_req)
              REQ_PAT_LETTER: begin
                if (built || !in_letter_ok) st <= ST_ORDER;
                else if (lost) st <= ST_FULL;
                else state <= S_PL_RD;
              end
              REQ_PAT_END: begin
                if (built) st <= ST_ORDER;
                else begin
                  lost <= 1'b0;
                  if (lost) begin
                    st      <= ST_FULL;
                    ins_cur <= '0;
                  end else begin
                    state <= S_PE_RD;
                  end
                end
              end
              REQ_BUILD: begin
                if (built) st <= ST_ORDER;
                else state <= S_B_INIT;
              end
              REQ_TXT_LETTER: begin
                if (!built || !in_letter_ok) st <= ST_ORDER;
                else begin
                  pn    <= mat_cur;
                  state <= S_T_RD;
                end
              end
              REQ_TXT_END: begin
                if (!built) st <= ST_ORDER;
                else mat_cur <= '0;
              end
              REQ_CLEAR: begin
                ins_cur     <= '0;
                mat_cur     <= '0;
                node_count  <= NCW'(1);
                match_sum   <= '0;
                built       <= 1'b0;
                lost        <= 1'b0;
                cidx        <= '0;
                clr_pending <= 1'b1;
                state       <= S_INIT;
              end
              default: st <= ST_ORDER;
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_data  <= {1'b0, USED_W'(node_count), TOTAL_W'(match_sum), st};
            state     <= S_IDLE;
          end
        end
        S_INIT: begin
          cidx <= cidx + 1'b1;
          if (cidx == C_LAST) begin
            clr_pending <= 1'b0;
            state       <= clr_pending ? S_DONE : S_IDLE;
          end
        end
        S_PL_RD: state <= S_PL_CHK;
        S_PL_CHK: begin
          if (c_rdata != '0) begin
            ins_cur <= c_rdata;
            state   <= S_DONE;
          end else if (node_count >= NCW'(MAX_NODES)) begin
            st    <= ST_FULL;
            lost  <= 1'b1;
            state <= S_DONE;
          end else begin
            ins_cur    <= AW'(node_count);
            node_count <= node_count + 1'b1;
            cidx       <= '0;
            state      <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          cidx <= cidx + 1'b1;
          if (cidx == C_LAST) state <= S_DONE;
        end
        S_PE_RD: state <= S_PE_WR;
        S_PE_WR: begin
          ins_cur <= '0;
          state   <= S_DONE;
        end
        S_B_INIT: begin
          head  <= '0;
          tail  <= NCW'(1);
          state <= S_B_POP;
        end
        S_B_POP: begin
          if (head == tail) begin
            built   <= 1'b1;
            ins_cur <= '0;
            lost    <= 1'b0;
            mat_cur <= '0;
            state   <= S_DONE;
          end else begin
            head  <= head + 1'b1;
            state <= S_B_T;
          end
        end
        S_B_T: begin
          tnode <= q_rdata;
          state <= S_B_TF;
        end
        S_B_TF: begin
          tfail <= nrd_fail;
          cidx  <= '0;
          state <= S_B_CRD;
        end
        S_B_CRD: begin
          if (cidx == CIW'(ALPHABET)) state <= S_B_POP;
          else state <= S_B_CCHK;
        end
        S_B_CCHK: begin
          if (c_rdata == '0) begin
            cidx  <= cidx + 1'b1;
            state <= S_B_CRD;
          end else begin
            chn <= c_rdata;
            if (tnode == '0) begin
              fval  <= '0;
              state <= S_B_WR;
            end else begin
              pn    <= tfail;
              state <= S_B_PRD;
            end
          end
        end
        S_B_PRD: state <= S_B_PCHK;
        S_B_PCHK: begin
          // follow failure links until some node has this child or the root is hit
          if (c_rdata != '0) begin
            fval  <= c_rdata;
            state <= S_B_WR;
          end else if (pn == '0) begin
            fval  <= '0;
            state <= S_B_WR;
          end else begin
            state <= S_B_PF;
          end
        end
        S_B_PF: begin
          pn    <= nrd_fail;
          state <= S_B_PRD;
        end
        S_B_WR: state <= S_B_WR2;
        S_B_WR2: begin
          tail  <= tail + 1'b1;
          cidx  <= cidx + 1'b1;
          state <= S_B_CRD;
        end
        S_T_RD: state <= S_T_CHK;
        S_T_CHK: begin
          if (c_rdata != '0 || pn == '0) begin
            mat_cur <= c_rdata;
            tnode   <= c_rdata;
            state   <= S_T_CNT;
          end else begin
            state <= S_T_F;
          end
        end
        S_T_F: begin
          pn    <= nrd_fail;
          state <= S_T_RD;
        end
        S_T_CNT: begin
          if (tnode == '0) state <= S_DONE;
          else state <= S_T_CNT2;
        end
        S_T_CNT2: begin
          if (nrd_mark) begin
            state <= S_DONE;
          end else begin
            match_sum <= sum_wide[COUNT_WIDTH] ? CNT_MAX : sum_wide[COUNT_WIDTH-1:0];
            tnode     <= nrd_fail;
            state     <= S_T_CNT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/mpsm_ram.sv
// generic simple dual-port ram with registered read
module mpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
